// ===== src/dpm_pkg.sv =====
// Shared types, constants and helpers for the delimiter pair matcher.
// No dependencies; imported by every module of the block but dpm_ram, and by the bench.
package dpm_pkg;

    localparam int STACK_DEPTH  = 12;
    localparam int PAIR_CLASSES = 5;
    localparam int ENTRIES      = PAIR_CLASSES * STACK_DEPTH;

    localparam int POS_W   = 32;
    localparam int KIND_W  = 4;
    localparam int CLASS_W = 3;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
    localparam int CLS_W   = (PAIR_CLASSES > 1) ? $clog2(PAIR_CLASSES) : 1;
    localparam int CNT_W   = $clog2(PAIR_CLASSES + 1);

    localparam int M_DATA_W = ((CLASS_W + POS_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] TOK_OPEN_BASE  = KIND_W'(1);
    localparam logic [KIND_W-1:0] TOK_CLOSE_BASE = KIND_W'(6);

    typedef enum logic [1:0] {
        REP_UNMATCHED = 2'd0,
        REP_UNCLOSED  = 2'd1,
        REP_OVERFLOW  = 2'd2,
        REP_DONE      = 2'd3
    } report_kind_t;

    typedef struct packed {
        logic               valid;
        report_kind_t       kind;
        logic [CLASS_W-1:0] pair_class;
        logic [POS_W-1:0]   position;
        logic               last;
    } result_t;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [CLS_W-1:0] cls,
                                                     input logic [LVL_W-1:0] lvl);
        logic [ADDR_W+LVL_W:0] sum;
        sum = (ADDR_W + LVL_W + 1)'(cls) * (ADDR_W + LVL_W + 1)'(STACK_DEPTH)
            + (ADDR_W + LVL_W + 1)'(lvl);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== src/delimiter_pair_matcher_unit.sv =====
// Delimiter pair matcher: one position stack per delimiter class in a shared RAM.
// Depends on dpm_pkg, dpm_ram and dpm_ctrl.
//
// Input channel (s_): one classified token per transaction; tuser carries the
// token kind, tdata the position, tlast the end of stream. Result channel (m_):
// tuser carries the report kind, tdata the class and position, tlast marks the
// final result caused by a token.
// Ordinary tokens, openers and closers are accepted back to back while the
// result register is free; each stack push is a single RAM write. An unmatched
// closer or an overflowing opener yields its result in the cycle after
// acceptance and aborts the rest of the stream. The last token of a stream that
// was not aborted starts a drain of the position RAM: each class is scanned in
// turn, each unclosed opener is read from the RAM and then emitted as a result,
// and the done result comes last; no token is taken during the drain.
// Results leave through a single output register; when the receiver stalls the
// result holds and the core waits, tokens that need no result slot included.
// Reset clears all stack levels, the abort flag and the output valid; RAM
// contents are never cleared, as only entries below a stack level are read.
module delimiter_pair_matcher_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // [31:0] token_position
    input  logic [3:0]                   s_tuser,   // [3:0] token_kind
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dpm_pkg::M_DATA_W-1:0] m_tdata,   // [2:0] pair_class, [34:3] position
    output logic [1:0]                   m_tuser,   // [1:0] report_kind
    output logic                         m_tlast
);
    import dpm_pkg::*;

    result_t              res;
    logic                 res_free;
    logic                 wr_en, rd_en;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [POS_W-1:0]     wr_data, rd_data;

    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [1:0]           m_tuser_reg;
    logic                 m_tlast_reg;

    assign res_free = !m_tvalid_reg || m_tready;

    dpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .tok_kind (s_tuser),
        .tok_pos  (s_tdata),
        .tok_last (s_tlast),
        .res_free (res_free),
        .res      (res),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    dpm_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (POS_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (res.valid) begin
            m_tdata_reg <= M_DATA_W'({res.position, res.pair_class});
            m_tuser_reg <= res.kind;
            m_tlast_reg <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== src/dpm_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// Generic; no package dependency.
module dpm_ram #(
    parameter int DEPTH = 60,
    parameter int WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dpm_ctrl.sv =====
// Stack controller: per-class levels, abort flag, end-of-stream drain sequencer.
// Depends on dpm_pkg; drives the position RAM (dpm_ram).
module dpm_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [dpm_pkg::KIND_W-1:0] tok_kind,
    input  logic [dpm_pkg::POS_W-1:0] tok_pos,
    input  logic                      tok_last,
    input  logic                      res_free,
    output dpm_pkg::result_t          res,
    output logic                      wr_en,
    output logic [dpm_pkg::ADDR_W-1:0] wr_addr,
    output logic [dpm_pkg::POS_W-1:0] wr_data,
    output logic                      rd_en,
    output logic [dpm_pkg::ADDR_W-1:0] rd_addr,
    input  logic [dpm_pkg::POS_W-1:0] rd_data
);
    import dpm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [LVL_W-1:0] level_reg [PAIR_CLASSES];
    logic [LVL_W-1:0] level_next [PAIR_CLASSES];
    logic             abort_reg, abort_next;
    logic [CNT_W-1:0] cls_reg, cls_next;
    logic [LVL_W-1:0] idx_reg, idx_next;

    logic             is_open, is_close, err;
    logic [KIND_W-1:0] open_off, close_off;
    logic [CLS_W-1:0] tok_cls, cur_cls;

    assign open_off  = tok_kind - TOK_OPEN_BASE;
    assign close_off = tok_kind - TOK_CLOSE_BASE;
    assign is_open   = (tok_kind >= TOK_OPEN_BASE) && (open_off < KIND_W'(PAIR_CLASSES));
    assign is_close  = (tok_kind >= TOK_CLOSE_BASE) && (close_off < KIND_W'(PAIR_CLASSES));
    assign tok_cls   = is_open ? open_off[CLS_W-1:0] : close_off[CLS_W-1:0];
    assign cur_cls   = cls_reg[CLS_W-1:0];

    always_comb begin
        state_next = state_reg;
        abort_next = abort_reg;
        cls_next   = cls_reg;
        idx_next   = idx_reg;
        for (int c = 0; c < PAIR_CLASSES; c++) begin
            level_next[c] = level_reg[c];
        end
        s_tready = 1'b0;
        res      = '0;
        err      = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = entry_addr(tok_cls, level_reg[tok_cls]);
        wr_data  = tok_pos;
        rd_en    = 1'b0;
        rd_addr  = entry_addr(cur_cls, idx_reg);

        case (state_reg)
            S_IDLE: begin
                s_tready = res_free;
                if (s_tvalid && res_free) begin
                    if (!abort_reg) begin
                        if (is_open) begin
                            if (level_reg[tok_cls] == LVL_W'(STACK_DEPTH)) begin
                                err = 1'b1;
                                res = '{1'b1, REP_OVERFLOW, CLASS_W'(tok_cls), tok_pos, 1'b1};
                            end else begin
                                wr_en = 1'b1;
                                level_next[tok_cls] = level_reg[tok_cls] + LVL_W'(1);
                            end
                        end else if (is_close) begin
                            if (level_reg[tok_cls] == '0) begin
                                err = 1'b1;
                                res = '{1'b1, REP_UNMATCHED, CLASS_W'(tok_cls), tok_pos, 1'b1};
                            end else begin
                                level_next[tok_cls] = level_reg[tok_cls] - LVL_W'(1);
                            end
                        end
                        if (err) begin
                            abort_next = 1'b1;
                        end
                    end
                    if (tok_last) begin
                        if (abort_reg || err) begin
                            abort_next = 1'b0;
                            for (int c = 0; c < PAIR_CLASSES; c++) begin
                                level_next[c] = '0;
                            end
                        end else begin
                            state_next = S_SCAN;
                            cls_next   = '0;
                            idx_next   = '0;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (cls_reg == CNT_W'(PAIR_CLASSES)) begin
                    if (res_free) begin
                        res        = '{1'b1, REP_DONE, '0, '0, 1'b1};
                        abort_next = 1'b0;
                        for (int c = 0; c < PAIR_CLASSES; c++) begin
                            level_next[c] = '0;
                        end
                        state_next = S_IDLE;
                    end
                end else if (idx_reg < level_reg[cur_cls]) begin
                    rd_en      = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    cls_next = cls_reg + CNT_W'(1);
                    idx_next = '0;
                end
            end
            S_EMIT: begin
                if (res_free) begin
                    res        = '{1'b1, REP_UNCLOSED, CLASS_W'(cur_cls), rd_data, 1'b0};
                    idx_next   = idx_reg + LVL_W'(1);
                    state_next = S_SCAN;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            abort_reg <= 1'b0;
            cls_reg   <= '0;
            idx_reg   <= '0;
            for (int c = 0; c < PAIR_CLASSES; c++) begin
                level_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            abort_reg <= abort_next;
            cls_reg   <= cls_next;
            idx_reg   <= idx_next;
            for (int c = 0; c < PAIR_CLASSES; c++) begin
                level_reg[c] <= level_next[c];
            end
        end
    end

endmodule

// ===== src/dpm_checker.sv =====
// Port-level checks for delimiter_pair_matcher_unit, attached by bind.
// Depends on dpm_pkg.
module dpm_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [dpm_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser,
    input logic                         m_tlast
);
    import dpm_pkg::*;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == REP_DONE) |-> (m_tdata == '0) && m_tlast)
        else $error("done result not empty or not last");

    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != REP_UNCLOSED)))
        else $error("tlast does not match report kind");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[CLASS_W-1:0] < CLASS_W'(PAIR_CLASSES)))
        else $error("class out of range");

endmodule

bind delimiter_pair_matcher_unit dpm_checker u_dpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for delimiter_pair_matcher_unit: per-class stack predictor,
// queued token driver, result monitor and stalling receiver.
// Depends on dpm_pkg and the RTL of the block; reads no files.
module tb_top;
    import dpm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_TOKENS = 365;

    localparam logic [KIND_W-1:0] KIND_OTHER = '0;
    localparam logic [KIND_W-1:0] KIND_SPARE = KIND_W'(TOK_CLOSE_BASE + PAIR_CLASSES);
    localparam logic [KIND_W-1:0] KIND_TOP   = '1;

    typedef enum int {
        STREAM_BALANCED,
        STREAM_DEEP,
        STREAM_BROKEN,
        STREAM_NOISE
    } stream_style_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic              last;
        int                phase;
        bit                drain_first;
    } token_t;

    typedef struct {
        report_kind_t       kind;
        logic [CLASS_W-1:0] cls;
        logic [POS_W-1:0]   pos;
        logic               last;
    } report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic [3:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    token_t  pending_tokens[$];
    report_t expected_reports[$];

    // predictor state
    logic [POS_W-1:0] opener_store [ENTRIES];
    int               class_level  [PAIR_CLASSES];
    bit               stream_dead;

    token_t cur_tok;
    int     cur_phase = 0;
    int     tokens_taken = 0;
    int     random_tokens = 0;
    int     hold_at = 32'h7FFF_FFFF;
    int     hold_left = 0;
    bit     hold_done = 1'b0;
    int     mismatches = 0;
    int     cycle_count = 0;

    delimiter_pair_matcher_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [KIND_W-1:0] open_kind(input int c);
        return KIND_W'(TOK_OPEN_BASE + c);
    endfunction

    function automatic logic [KIND_W-1:0] close_kind(input int c);
        return KIND_W'(TOK_CLOSE_BASE + c);
    endfunction

    function automatic int tx_idle_pct(input int ph);
        case (ph)
            0:       return 26;
            1:       return 76;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(input int ph);
        case (ph)
            0:       return 76;
            1:       return 26;
            default: return 0;
        endcase
    endfunction

    function automatic void push_report(input report_kind_t k, input int c,
                                        input logic [POS_W-1:0] p, input logic l);
        report_t r;
        r.kind = k;
        r.cls  = CLASS_W'(c);
        r.pos  = p;
        r.last = l;
        expected_reports.push_back(r);
    endfunction

    function automatic void predict_reports(input token_t t);
        int c;
        int i;
        if (!stream_dead) begin
            if (t.kind >= TOK_OPEN_BASE && t.kind < TOK_OPEN_BASE + PAIR_CLASSES) begin
                c = int'(t.kind - TOK_OPEN_BASE);
                if (class_level[c] >= STACK_DEPTH) begin
                    push_report(REP_OVERFLOW, c, t.pos, 1'b1);
                    stream_dead = 1'b1;
                end else begin
                    opener_store[c * STACK_DEPTH + class_level[c]] = t.pos;
                    class_level[c]++;
                end
            end else if (t.kind >= TOK_CLOSE_BASE &&
                         t.kind < TOK_CLOSE_BASE + PAIR_CLASSES) begin
                c = int'(t.kind - TOK_CLOSE_BASE);
                if (class_level[c] == 0) begin
                    push_report(REP_UNMATCHED, c, t.pos, 1'b1);
                    stream_dead = 1'b1;
                end else begin
                    class_level[c]--;
                end
            end
            if (t.last && !stream_dead) begin
                for (c = 0; c < PAIR_CLASSES; c++)
                    for (i = 0; i < class_level[c]; i++)
                        push_report(REP_UNCLOSED, c, opener_store[c * STACK_DEPTH + i], 1'b0);
                push_report(REP_DONE, 0, '0, 1'b1);
            end
        end
        if (t.last) begin
            for (c = 0; c < PAIR_CLASSES; c++)
                class_level[c] = 0;
            stream_dead = 1'b0;
        end
    endfunction

    task automatic push_token(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                              input logic l, input int ph, input bit hold);
        token_t t;
        t.kind        = k;
        t.pos         = p;
        t.last        = l;
        t.phase       = ph;
        t.drain_first = hold;
        pending_tokens.push_back(t);
    endtask

    task automatic make_stream(input stream_style_t style, input int ph, input bit hold);
        int                glvl[PAIR_CLASSES];
        int                len;
        int                n;
        int                c;
        int                k;
        bit                dead;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        for (c = 0; c < PAIR_CLASSES; c++)
            glvl[c] = 0;
        dead = 1'b0;
        len = (style == STREAM_DEEP) ? $urandom_range(20, 64) : $urandom_range(1, 24);
        for (n = 0; n < len; n++) begin
            c = $urandom_range(0, PAIR_CLASSES - 1);
            k = $urandom_range(0, 99);
            case (style)
                STREAM_DEEP: begin
                    if (k < 3 || (k < 85 && glvl[c] < STACK_DEPTH))
                        kind = open_kind(c);
                    else if (glvl[c] > 0)
                        kind = close_kind(c);
                    else
                        kind = KIND_OTHER;
                end
                STREAM_NOISE: kind = KIND_W'($urandom_range(0, 15));
                default: begin
                    if (style == STREAM_BROKEN && k < 8)
                        kind = close_kind(c);
                    else if (style == STREAM_BROKEN && k < 14)
                        kind = open_kind(c);
                    else if (k < 10)
                        kind = ($urandom_range(0, 1) != 0) ? KIND_OTHER
                                                           : KIND_W'($urandom_range(11, 15));
                    else if ((k < 55 || glvl[c] == 0) && glvl[c] < STACK_DEPTH)
                        kind = open_kind(c);
                    else
                        kind = close_kind(c);
                end
            endcase
            pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 255)) : $urandom;
            if (!dead) begin
                random_tokens++;
                if (kind >= TOK_OPEN_BASE && kind < TOK_OPEN_BASE + PAIR_CLASSES) begin
                    c = int'(kind - TOK_OPEN_BASE);
                    if (glvl[c] >= STACK_DEPTH) dead = 1'b1;
                    else glvl[c]++;
                end else if (kind >= TOK_CLOSE_BASE &&
                             kind < TOK_CLOSE_BASE + PAIR_CLASSES) begin
                    c = int'(kind - TOK_CLOSE_BASE);
                    if (glvl[c] == 0) dead = 1'b1;
                    else glvl[c]--;
                end
                // trail a few ignored tokens after an abort
                if (dead && len > n + 4)
                    len = n + 1 + $urandom_range(0, 3);
            end
            push_token(kind, pos, n == len - 1, ph, hold && n == 0);
        end
    endtask

    task automatic report_mismatch(input string what, input report_t exp, input report_t act);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s): expected kind %0d class %0d pos %h last %b, ",
                      "got kind %0d class %0d pos %h last %b"},
                     what, exp.kind, exp.cls, exp.pos, exp.last,
                     act.kind, act.cls, act.pos, act.last);
    endtask

    // stimulus
    initial begin
        int            i;
        int            ph;
        int            prev_ph;
        int            s;
        stream_style_t style;

        for (i = 0; i < PAIR_CLASSES; i++)
            class_level[i] = 0;
        stream_dead = 1'b0;

        push_token(open_kind(0), 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
        push_token(open_kind(1), 32'h0000_0000, 1'b0, 0, 1'b0);
        push_token(open_kind(2), 32'hA5A5_5A5A, 1'b0, 0, 1'b0);
        push_token(open_kind(3), 32'h0000_0001, 1'b0, 0, 1'b0);
        push_token(open_kind(4), 32'h8000_0000, 1'b0, 0, 1'b0);
        push_token(close_kind(1), 32'h1234_5678, 1'b0, 0, 1'b0);
        push_token(KIND_OTHER, 32'h5555_AAAA, 1'b0, 0, 1'b0);
        push_token(KIND_TOP, 32'hFFFF_FFFF, 1'b0, 0, 1'b0);
        push_token(close_kind(0), 32'h0000_0000, 1'b0, 0, 1'b0);
        push_token(KIND_SPARE, 32'hDEAD_BEEF, 1'b1, 0, 1'b0);
        // unmatched closer, then the rest of the stream is ignored
        push_token(close_kind(3), 32'h0000_0042, 1'b0, 0, 1'b0);
        push_token(open_kind(0), 32'h0000_0007, 1'b0, 0, 1'b0);
        push_token(close_kind(0), 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        // fill one class, overflow on the last token
        for (i = 0; i < STACK_DEPTH; i++)
            push_token(open_kind(4), 32'h1111_1111 * i, 1'b0, 0, 1'b0);
        push_token(open_kind(4), 32'hCAFE_F00D, 1'b1, 0, 1'b0);
        // empty stream
        push_token(KIND_OTHER, 32'h0000_0000, 1'b1, 0, 1'b0);

        prev_ph = 0;
        while (random_tokens < RANDOM_TOKENS) begin
            ph = random_tokens * 3 / RANDOM_TOKENS;
            s = $urandom_range(0, 19);
            if (s < 12)      style = STREAM_BALANCED;
            else if (s < 15) style = STREAM_DEEP;
            else if (s < 18) style = STREAM_BROKEN;
            else             style = STREAM_NOISE;
            if (ph == 2 && prev_ph != 2)
                hold_at = pending_tokens.size() + 10;
            make_stream(style, ph, ph == 1 && prev_ph == 0);
            prev_ph = ph;
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pending_tokens.size() != 0 || s_tvalid || expected_reports.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (expected_reports.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", expected_reports.size());
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // token driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_reports(cur_tok);
                tokens_taken++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else if (pending_tokens.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_tokens[0].drain_first && expected_reports.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if ($urandom_range(0, 99) < tx_idle_pct(pending_tokens[0].phase)) begin
                s_tvalid <= 1'b0;
            end else begin
                cur_tok   = pending_tokens.pop_front();
                cur_phase = cur_tok.phase;
                s_tvalid <= 1'b1;
                s_tdata  <= cur_tok.pos;
                s_tuser  <= cur_tok.kind;
                s_tlast  <= cur_tok.last;
            end
        end
    end

    // result receiver with one long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (!hold_done && tokens_taken >= hold_at) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct(cur_phase));
        end
    end

    // result monitor
    always @(posedge aclk) begin
        report_t got;
        report_t exp;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = report_kind_t'(m_tuser);
            got.cls  = m_tdata[CLASS_W-1:0];
            got.pos  = m_tdata[CLASS_W +: POS_W];
            got.last = m_tlast;
            if (expected_reports.size() == 0) begin
                exp = '{REP_UNMATCHED, '0, '0, 1'b0};
                report_mismatch("unexpected result", exp, got);
            end else begin
                exp = expected_reports.pop_front();
                if (got.kind !== exp.kind || got.cls !== exp.cls ||
                    got.pos !== exp.pos || got.last !== exp.last)
                    report_mismatch("field", exp, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
src/dpm_pkg.sv
src/dpm_ram.sv
src/dpm_ctrl.sv
src/delimiter_pair_matcher_unit.sv
src/dpm_checker.sv
bench/tb_top.sv
